/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* hw/rtl/safp_pkg.sv */
`timescale 1ns / 1ps
package safp_pkg;
   localparam int DimBits = 13;
   localparam int FracBits = 12;
   localparam int ScaleBits = 16;
   localparam int OffBits = 16;
   localparam int PosBits = 20;
   localparam int SizeBits = 18;
   localparam int ModeBits = 4;
   localparam int NumBits = 2 * DimBits + ScaleBits;
   localparam int DenBits = DimBits + FracBits;
   localparam int QuoBits = NumBits;
   localparam logic [SizeBits-1:0] SizeMax = '1;

   localparam logic [ModeBits-1:0] ModeTr = 4'd1;
   localparam logic [ModeBits-1:0] ModeBl = 4'd2;
   localparam logic [ModeBits-1:0] ModeBr = 4'd3;
   localparam logic [ModeBits-1:0] ModeTop = 4'd4;
   localparam logic [ModeBits-1:0] ModeBottom = 4'd5;
   localparam logic [ModeBits-1:0] ModeLeft = 4'd6;
   localparam logic [ModeBits-1:0] ModeRight = 4'd7;
   localparam logic [ModeBits-1:0] ModeCenter = 4'd8;
   localparam logic [ModeBits-1:0] ModeFwb = 4'd9;
   localparam logic [ModeBits-1:0] ModeFit = 4'd10;
   localparam logic [ModeBits-1:0] ModeFill = 4'd11;

   localparam logic [1:0] RegLw = 2'd0;
   localparam logic [1:0] RegLh = 2'd1;
   localparam logic [1:0] RegOw = 2'd2;
   localparam logic [1:0] RegOh = 2'd3;

   typedef struct packed {
      logic                       valid;
      logic [ModeBits-1:0]        mode;
      logic [DimBits-1:0]         sw;
      logic [DimBits-1:0]         sh;
      logic signed [OffBits-1:0]  dx;
      logic signed [OffBits-1:0]  dy;
   } ctl_type;

   typedef struct packed {
      logic [NumBits-1:0] rem_w;
      logic [NumBits-1:0] rem_h;
      logic [QuoBits-1:0] quo_w;
      logic [QuoBits-1:0] quo_h;
      logic [DenBits-1:0] den;
   } div_type;

   function automatic logic [SizeBits-1:0] clamp_size(input logic [QuoBits-1:0] q);
      logic [SizeBits-1:0] r;
      if (q == '0) r = {{(SizeBits-1){1'b0}}, 1'b1};
      else if (q > QuoBits'(SizeMax)) r = SizeMax;
      else r = q[SizeBits-1:0];
      return r;
   endfunction
endpackage

/* hw/rtl/sprite_anchor_fit_placement.sv */
`timescale 1ns / 1ps
// Fully pipelined placement: one item enters per cycle unless the output stalls, and
// passes 46 register stages (operand capture, multiply, numerator products, 42 divider
// steps at one quotient bit each, place); the place stage holds the offered result.
// A stall holds every stage. Configuration is written with csr_wr_en, index and data.
module sprite_anchor_fit_placement (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // image_width[12:0], image_height[25:13], place_mode[29:26], scale_factor[45:30],
   // shift_x[61:46], shift_y[77:62], zeros[79:78]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rect_x[19:0], rect_y[39:20], rect_w[57:40], rect_h[75:58], rect_valid[76], zeros
   output logic [79:0] rsp_tdata
);
   import safp_pkg::*;
   `include "assert_macros.svh"

   localparam int Steps = QuoBits;
   localparam int Depth = Steps + 4;

   logic [DimBits-1:0] lw_ff, lh_ff, ow_ff, oh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff <= '0; lh_ff <= '0; ow_ff <= '0; oh_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            RegLw: lw_ff <= csr_wdata;
            RegLh: lh_ff <= csr_wdata;
            RegOw: ow_ff <= csr_wdata;
            RegOh: oh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   logic [Depth-1:0] vld_ff;
   assign adv = !vld_ff[Depth-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
   end

   // Stage 0: operand capture.
   ctl_type c0_ff;
   logic [DimBits-1:0] iw0_ff, ih0_ff;
   logic [ScaleBits-1:0] s0_ff;
   logic [DimBits-1:0] sw_sel, sh_sel;
   always_comb begin
      sw_sel = lw_ff; sh_sel = lh_ff;
      if (lw_ff == '0 || lh_ff == '0) begin
         sw_sel = ow_ff; sh_sel = oh_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         iw0_ff <= req_tdata[12:0];
         ih0_ff <= req_tdata[25:13];
         s0_ff <= req_tdata[45:30];
         c0_ff.mode <= req_tdata[29:26];
         c0_ff.dx <= req_tdata[61:46];
         c0_ff.dy <= req_tdata[77:62];
         c0_ff.sw <= sw_sel;
         c0_ff.sh <= sh_sel;
         c0_ff.valid <= req_tdata[12:0] != '0 && req_tdata[25:13] != '0 &&
                        sw_sel != '0 && sh_sel != '0;
      end
   end

   // Stage 1: ratio choice and first products.
   logic [2*DimBits-1:0] cw, ch;
   logic use_w, fitm;
   logic [DimBits-1:0] n0, d0;
   assign cw = c0_ff.sw * ih0_ff;
   assign ch = c0_ff.sh * iw0_ff;
   always_comb begin
      fitm = c0_ff.mode == ModeFwb || c0_ff.mode == ModeFit || c0_ff.mode == ModeFill;
      use_w = 1'b1;
      if (c0_ff.mode == ModeFit) use_w = cw <= ch;
      else if (c0_ff.mode == ModeFill) use_w = !(cw <= ch);
      n0 = use_w ? c0_ff.sw : c0_ff.sh;
      d0 = use_w ? iw0_ff : ih0_ff;
   end
   ctl_type c1_ff;
   logic [DimBits+ScaleBits-1:0] pw1_ff, ph1_ff;
   logic [DimBits-1:0] n1_ff, d1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff <= c0_ff;
         pw1_ff <= iw0_ff * s0_ff;
         ph1_ff <= ih0_ff * s0_ff;
         n1_ff <= fitm ? n0 : {{(DimBits-1){1'b0}}, 1'b1};
         d1_ff <= fitm ? d0 : {{(DimBits-1){1'b0}}, 1'b1};
      end
   end

   // Stage 2: numerators and denominator.
   div_type dv_ff [Steps+1];
   ctl_type cp_ff [Steps+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0].rem_w <= pw1_ff * n1_ff;
         dv_ff[0].rem_h <= ph1_ff * n1_ff;
         dv_ff[0].quo_w <= '0;
         dv_ff[0].quo_h <= '0;
         dv_ff[0].den <= DenBits'(d1_ff) << FracBits;
         cp_ff[0] <= c1_ff;
      end
   end

   genvar g;
   generate
      for (g = 0; g < Steps; g++) begin : g_div
         div_type nx;
         safp_divstage u_st (.d_in(dv_ff[g]), .bit_pos(6'(Steps-1-g)), .d_out(nx));
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_ff[g+1] <= nx;
               cp_ff[g+1] <= cp_ff[g];
            end
         end
      end
   endgenerate

   // Final stage: clamp and place.
   ctl_type cf;
   logic [SizeBits-1:0] w, h;
   logic signed [PosBits+1:0] rgt, bot, cx, cy, x, y;
   assign cf = cp_ff[Steps];
   always_comb begin
      w = clamp_size(dv_ff[Steps].quo_w);
      h = clamp_size(dv_ff[Steps].quo_h);
      rgt = $signed({9'd0, cf.sw}) - $signed({4'd0, w});
      bot = $signed({9'd0, cf.sh}) - $signed({4'd0, h});
      cx = rgt / 22'sd2;
      cy = bot / 22'sd2;
      x = '0; y = '0;
      case (cf.mode)
         ModeTr: x = rgt;
         ModeBl: y = bot;
         ModeBr: begin x = rgt; y = bot; end
         ModeTop: x = cx;
         ModeBottom: begin x = cx; y = bot; end
         ModeLeft: y = cy;
         ModeRight: begin x = rgt; y = cy; end
         ModeCenter, ModeFit, ModeFill: begin x = cx; y = cy; end
         ModeFwb: y = bot;
         default: ;
      endcase
      x = x + cf.dx;
      y = y + cf.dy;
   end
   logic [79:0] out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (cf.valid) out_ff <= {3'd0, 1'b1, h, w, y[PosBits-1:0], x[PosBits-1:0]};
         else out_ff <= '0;
      end
   end
   assign rsp_tvalid = vld_ff[Depth-1];
   assign rsp_tdata = out_ff;

   `ASSERT_CLK(a_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata), "result changed under stall")
   `ASSERT_CLK(a_rdy, clock, reset, (!rsp_tvalid) |-> req_tready, "not ready with empty output")
   `ASSERT_CLK(a_vw, clock, reset, (rsp_tvalid && rsp_tdata[76]) |-> rsp_tdata[57:40] != '0, "valid rect with zero width")
endmodule

/* hw/rtl/safp_divstage.sv */
`timescale 1ns / 1ps
// One restoring step of the width and height dividers.
module safp_divstage (
   input  safp_pkg::div_type d_in,
   input  logic [5:0]        bit_pos,
   output safp_pkg::div_type d_out
);
   import safp_pkg::*;
   logic [NumBits+DenBits-1:0] dsh;
   always_comb begin
      dsh = (NumBits+DenBits)'(d_in.den) << bit_pos;
      d_out = d_in;
      if ((NumBits+DenBits)'(d_in.rem_w) >= dsh) begin
         d_out.rem_w = d_in.rem_w - dsh[NumBits-1:0];
         d_out.quo_w[bit_pos] = 1'b1;
      end
      if ((NumBits+DenBits)'(d_in.rem_h) >= dsh) begin
         d_out.rem_h = d_in.rem_h - dsh[NumBits-1:0];
         d_out.quo_h[bit_pos] = 1'b1;
      end
   end
endmodule
